// File: rtl/core/qgi_pkg.sv
// Package with payload types and constants for the quaternion gyro integrator.
`timescale 1ns / 1ps
`default_nettype none
package qgi_pkg;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic               restart;
    } gyro_in_t;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic               norm_fault;
    } quat_out_t;

    localparam logic [31:0] HALF_PERIOD_RESET = 32'd2147484;
    localparam logic signed [31:0] QUAT_ONE = 32'sh4000_0000;
    localparam logic signed [63:0] COMP_MAX = 64'sd2147483647;

endpackage
`default_nettype wire

// File: rtl/core/qgi_mul.sv
// Radix-2 serial signed multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qgi_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [45:0] mcand,
    input  wire logic signed [45:0] mplier,
    output logic                    done,
    output logic signed [91:0]      product
);

    logic [5:0]          cnt_reg;
    logic                busy_reg;
    logic signed [91:0]  acc_reg;
    logic signed [91:0]  mc_reg;
    logic [45:0]         mp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd45)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mc_reg  <= 92'(mcand);
            mp_reg  <= mplier;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                if (cnt_reg == 6'd45)
                    acc_reg <= acc_reg - mc_reg;
                else
                    acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= mc_reg <<< 1;
            mp_reg <= mp_reg >> 1;
        end
    end

    assign product = acc_reg;

endmodule
`default_nettype wire

// File: rtl/core/qgi_sqrt.sv
// Serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qgi_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [33:0] trial;

    assign trial = {rem_reg[31:0], rad_reg[63:62]} - {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (!trial[33])
            begin
                rem_reg  <= trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[31:0], rad_reg[63:62]};
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign root = root_reg;

endmodule
`default_nettype wire

// File: rtl/core/qgi_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qgi_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [61:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [61:0]      quotient
);

    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [61:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted = {rem_reg[31:0], quo_reg[61]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd61)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_reg <= diff[32:0];
                quo_reg <= {quo_reg[60:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[60:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;

endmodule
`default_nettype wire

// File: rtl/core/quaternion_gyro_integrator.sv
// Top level: sequencer for quaternion integration and renormalization.
// A transaction runs 24 products on a bit-serial multiplier, a square root and four
// divisions before a valid result. A zero norm skips the divisions, and a restart
// transaction skips all arithmetic. The next input is taken only in idle, once the
// result register is free, i.e. the previous result has been taken. Reset loads identity.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_gyro_integrator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire qgi_pkg::gyro_in_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output qgi_pkg::quat_out_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RMUL, ST_RWAIT, ST_PMUL, ST_PWAIT, ST_SQ, ST_SQWAIT,
        ST_ROOT, ST_RTWAIT, ST_DIV, ST_DWAIT, ST_DONE
    } state_t;

    state_t              state_reg;
    logic [31:0]         hp_reg;
    logic signed [31:0]  att_reg [4];
    logic signed [31:0]  g_reg [3];
    logic signed [45:0]  s_reg [4];
    logic signed [31:0]  n_reg [4];
    logic signed [45:0]  part_reg;
    logic [63:0]         sum_reg;
    logic [31:0]         norm_reg;
    logic [3:0]          term_reg;
    logic [1:0]          row_reg;
    logic                half_reg;

    logic                mul_start;
    logic signed [45:0]  mul_a;
    logic signed [45:0]  mul_b;
    logic                mul_done;
    logic signed [91:0]  mul_p;
    logic                sq_start;
    logic                sq_done;
    logic [31:0]         sq_root;
    logic                div_start;
    logic                div_done;
    logic [61:0]         div_q;
    logic [31:0]         mag;

    logic [1:0]          t_row;
    logic [1:0]          t_q;
    logic [1:0]          t_g;
    logic                t_neg;
    logic signed [45:0]  term;
    logic signed [45:0]  incr;
    logic signed [63:0]  nsum;
    logic signed [31:0]  nsat;
    logic [31:0]         qsat;

    // Term k: row, quaternion index, rate index and sign of the product.
    always_comb
    begin
        case (term_reg)
            4'd0:    begin t_row = 2'd0; t_q = 2'd1; t_g = 2'd0; t_neg = 1'b1; end
            4'd1:    begin t_row = 2'd0; t_q = 2'd2; t_g = 2'd1; t_neg = 1'b1; end
            4'd2:    begin t_row = 2'd0; t_q = 2'd3; t_g = 2'd2; t_neg = 1'b1; end
            4'd3:    begin t_row = 2'd1; t_q = 2'd0; t_g = 2'd0; t_neg = 1'b0; end
            4'd4:    begin t_row = 2'd1; t_q = 2'd2; t_g = 2'd2; t_neg = 1'b0; end
            4'd5:    begin t_row = 2'd1; t_q = 2'd3; t_g = 2'd1; t_neg = 1'b1; end
            4'd6:    begin t_row = 2'd2; t_q = 2'd0; t_g = 2'd1; t_neg = 1'b0; end
            4'd7:    begin t_row = 2'd2; t_q = 2'd1; t_g = 2'd2; t_neg = 1'b1; end
            4'd8:    begin t_row = 2'd2; t_q = 2'd3; t_g = 2'd0; t_neg = 1'b0; end
            4'd9:    begin t_row = 2'd3; t_q = 2'd0; t_g = 2'd2; t_neg = 1'b0; end
            4'd10:   begin t_row = 2'd3; t_q = 2'd1; t_g = 2'd1; t_neg = 1'b0; end
            4'd11:   begin t_row = 2'd3; t_q = 2'd2; t_g = 2'd0; t_neg = 1'b1; end
            default: begin t_row = 2'd0; t_q = 2'd0; t_g = 2'd0; t_neg = 1'b0; end
        endcase
    end

    assign term = 46'(mul_p >>> 20);
    assign incr = 46'((mul_p + 92'(part_reg)) >>> 16);
    assign nsum = 64'(att_reg[row_reg]) + 64'(incr);
    always_comb
    begin
        if (nsum > qgi_pkg::COMP_MAX)
            nsat = 32'(qgi_pkg::COMP_MAX);
        else if (nsum < -qgi_pkg::COMP_MAX)
            nsat = 32'(-qgi_pkg::COMP_MAX);
        else
            nsat = 32'(nsum);
    end

    assign mag  = n_reg[row_reg][31] ? 32'(-n_reg[row_reg]) : 32'(n_reg[row_reg]);
    assign qsat = (div_q > 62'd2147483647) ? 32'h7FFF_FFFF : div_q[31:0];

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_RMUL:
            begin
                mul_start = 1'b1;
                mul_a     = 46'(att_reg[t_q]);
                mul_b     = 46'(g_reg[t_g]);
            end
            ST_PMUL:
            begin
                mul_start = 1'b1;
                mul_a     = s_reg[row_reg];
                mul_b     = half_reg ? 46'({1'b0, hp_reg[31:16]})
                                     : 46'({1'b0, hp_reg[15:0]});
            end
            ST_SQ:
            begin
                mul_start = 1'b1;
                mul_a     = 46'(n_reg[row_reg]);
                mul_b     = 46'(n_reg[row_reg]);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign sq_start  = (state_reg == ST_ROOT);
    assign div_start = (state_reg == ST_DIV);
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid;
    assign cfg_ready = 1'b1;

    qgi_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .mcand(mul_a), .mplier(mul_b),
        .done(mul_done), .product(mul_p)
    );

    qgi_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_reg),
        .done(sq_done), .root(sq_root)
    );

    qgi_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend({mag, 30'd0}),
        .divisor(norm_reg), .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hp_reg     <= qgi_pkg::HALF_PERIOD_RESET;
            att_reg[0] <= qgi_pkg::QUAT_ONE;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
            out_valid  <= 1'b0;
            term_reg   <= '0;
            row_reg    <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                hp_reg <= cfg_data;
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        g_reg[0] <= in_data.rate_x;
                        g_reg[1] <= in_data.rate_y;
                        g_reg[2] <= in_data.rate_z;
                        if (in_data.restart)
                        begin
                            att_reg[0] <= qgi_pkg::QUAT_ONE;
                            att_reg[1] <= '0;
                            att_reg[2] <= '0;
                            att_reg[3] <= '0;
                            out_data <= '{qgi_pkg::QUAT_ONE, '0, '0, '0, 1'b0};
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            term_reg  <= '0;
                            s_reg[0] <= '0;
                            s_reg[1] <= '0;
                            s_reg[2] <= '0;
                            s_reg[3] <= '0;
                            state_reg <= ST_RMUL;
                        end
                    end
                end
                ST_RMUL:
                begin
                    state_reg <= ST_RWAIT;
                end
                ST_RWAIT:
                begin
                    if (mul_done)
                    begin
                        if (t_neg)
                            s_reg[t_row] <= s_reg[t_row] - term;
                        else
                            s_reg[t_row] <= s_reg[t_row] + term;
                        term_reg <= term_reg + 4'd1;
                        if (term_reg == 4'd11)
                        begin
                            row_reg   <= '0;
                            half_reg  <= 1'b0;
                            state_reg <= ST_PMUL;
                        end
                        else
                            state_reg <= ST_RMUL;
                    end
                end
                ST_PMUL:
                begin
                    state_reg <= ST_PWAIT;
                end
                ST_PWAIT:
                begin
                    if (mul_done)
                    begin
                        if (!half_reg)
                        begin
                            part_reg  <= 46'(mul_p >>> 16);
                            half_reg  <= 1'b1;
                            state_reg <= ST_PMUL;
                        end
                        else
                        begin
                            half_reg <= 1'b0;
                            row_reg  <= row_reg + 2'd1;
                            state_reg <= ST_PMUL;
                            if (row_reg == 2'd3)
                            begin
                                sum_reg   <= '0;
                                state_reg <= ST_SQ;
                            end
                        end
                    end
                end
                ST_SQ:
                begin
                    state_reg <= ST_SQWAIT;
                end
                ST_SQWAIT:
                begin
                    if (mul_done)
                    begin
                        sum_reg <= sum_reg + mul_p[63:0];
                        row_reg <= row_reg + 2'd1;
                        state_reg <= (row_reg == 2'd3) ? ST_ROOT : ST_SQ;
                    end
                end
                ST_ROOT:
                begin
                    state_reg <= ST_RTWAIT;
                end
                ST_RTWAIT:
                begin
                    if (sq_done)
                    begin
                        norm_reg <= sq_root;
                        if (sq_root == '0)
                        begin
                            att_reg[0] <= qgi_pkg::QUAT_ONE;
                            att_reg[1] <= '0;
                            att_reg[2] <= '0;
                            att_reg[3] <= '0;
                            out_data <= '{qgi_pkg::QUAT_ONE, '0, '0, '0, 1'b1};
                            state_reg <= ST_DONE;
                        end
                        else
                            state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (div_done)
                    begin
                        att_reg[row_reg] <= n_reg[row_reg][31] ? -$signed(qsat)
                                                               : $signed(qsat);
                        row_reg <= row_reg + 2'd1;
                        state_reg <= ST_DIV;
                        if (row_reg == 2'd3)
                        begin
                            out_data.quat_w <= att_reg[0];
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    out_data.quat_w     <= att_reg[0];
                    out_data.quat_x     <= att_reg[1];
                    out_data.quat_y     <= att_reg[2];
                    out_data.quat_z     <= att_reg[3];
                    out_data.norm_fault <= (norm_reg == '0);
                    out_valid <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if ((state_reg == ST_PWAIT) && mul_done && half_reg)
                n_reg[row_reg] <= nsat;
            if ((state_reg == ST_IDLE) && in_valid && in_ready)
                norm_reg <= 32'd1;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({mul_done, sq_done, div_done}) <= 1)
        else $error("two units finished together");
`endif

endmodule
`default_nettype wire
